@@ rtl/core/mwa_pkg.sv @@
// ----------------------------------------------------------------------------
// mwa_pkg
// Shared types and constants of the max-weight assignment solver.
// ----------------------------------------------------------------------------
package mwa_pkg;

  localparam int OUT_COL_W  = 4;
  localparam int OUT_ROW_W  = 4;
  localparam int PAIR_W     = 16;
  localparam int TOTAL_W    = 20;
  localparam int CFG_SIZE_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int APB_ADDR_W = 3;

  // register indexes
  localparam logic REG_SIZE_IN_USE = 1'b0;

  typedef enum logic [13:0] {
    ST_LOAD      = 14'b00000000000001,
    ST_MAX_A     = 14'b00000000000010,
    ST_MAX_B     = 14'b00000000000100,
    ST_ROOT      = 14'b00000000001000,
    ST_TOP       = 14'b00000000010000,
    ST_SCAN      = 14'b00000000100000,
    ST_TEST      = 14'b00000001000000,
    ST_AUG       = 14'b00000010000000,
    ST_REL_A     = 14'b00000100000000,
    ST_REL_B     = 14'b00001000000000,
    ST_REL_APPLY = 14'b00010000000000,
    ST_OUT_A     = 14'b00100000000000,
    ST_OUT_B     = 14'b01000000000000,
    ST_OUT_C     = 14'b10000000000000
  } mwa_state_e;

  // status of the shared slack unit
  typedef struct packed {
    logic tight;    // current slack is zero
    logic better;   // current slack beats the running minimum
    logic positive; // a minimum was found and it is above zero
  } slack_flags_t;

endpackage

@@ rtl/core/mwa_if.sv @@
// ----------------------------------------------------------------------------
// mwa_if
// Valid/ready channels for weights in and assignment pairs out.
// ----------------------------------------------------------------------------
interface mwa_in_if #(
  parameter int WEIGHT_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [WEIGHT_BITS-1:0] weight;

  modport source (output valid, output weight, input ready);
  modport sink   (input valid, input weight, output ready);
endinterface

interface mwa_out_if;
  import mwa_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [OUT_COL_W-1:0] column;
  logic [OUT_ROW_W-1:0] assigned_row;
  logic [PAIR_W-1:0]    pair_weight;
  logic [TOTAL_W-1:0]   running_total;
  logic                 last;

  modport source (output valid, output column, output assigned_row, output pair_weight,
                  output running_total, output last, input ready);
  modport sink   (input valid, input column, input assigned_row, input pair_weight,
                  input running_total, input last, output ready);
endinterface

@@ rtl/core/mwa_ram.sv @@
// ----------------------------------------------------------------------------
// mwa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/mwa_slack.sv @@
// ----------------------------------------------------------------------------
// mwa_slack
// Shared slack unit: row label plus column label minus weight, with the
// running minimum used by the label update.
// ----------------------------------------------------------------------------
module mwa_slack import mwa_pkg::*; #(
  parameter int WEIGHT_BITS = 16,
  parameter int LW          = 22
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic signed [LW-1:0]   row_label_i,
  input  logic signed [LW-1:0]   col_label_i,
  input  logic [WEIGHT_BITS-1:0] weight_i,
  input  logic                   clear_i,
  input  logic                   take_i,
  output slack_flags_t           flags_o,
  output logic signed [LW-1:0]   min_o
);

  logic signed [LW:0] slack;
  logic signed [LW:0] min_q, min_d;
  logic               found_q, found_d;

  assign slack = $signed({row_label_i[LW-1], row_label_i})
               + $signed({col_label_i[LW-1], col_label_i})
               - $signed({{(LW + 1 - WEIGHT_BITS){1'b0}}, weight_i});

  assign flags_o.tight    = (slack == '0);
  assign flags_o.better   = !found_q || (slack < min_q);
  assign flags_o.positive = found_q && (min_q > 0);
  assign min_o            = min_q[LW-1:0];

  always_comb begin
    min_d   = min_q;
    found_d = found_q;
    if (clear_i) begin
      found_d = 1'b0;
    end else if (take_i && flags_o.better) begin
      min_d   = slack;
      found_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    min_q <= min_d;
  end

endmodule

@@ rtl/core/max_weight_assignment_solver_top.sv @@
// ----------------------------------------------------------------------------
// max_weight_assignment_solver_top
// Kuhn-Munkres maximum-weight assignment over a loaded square matrix.
// ----------------------------------------------------------------------------
// Weights of an n x n matrix (n = size_in_use) enter row-major, one per cycle
// while the input is ready, into a weight RAM. The last weight starts the
// solve, during which the input is not ready: the row maxima first, then per
// root row a depth-first search that starts, tries columns, pops the stack
// and augments pair by pair, and a label update whenever a search fails;
// every weight read goes through the single registered RAM read port and one
// shared slack unit. Results then leave at one per column, each one read,
// registered and then held until the sink is ready. Writing size_in_use
// clears the row and column counters, which restarts loading in the load
// state; the solve and output states carry on.
module max_weight_assignment_solver_top import mwa_pkg::*; #(
  parameter int MAX_SIZE    = 16,
  parameter int WEIGHT_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mwa_in_if.sink                wt_chan_i,
  mwa_out_if.source             res_chan_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int IDXW   = $clog2(MAX_SIZE);
  localparam int CW     = IDXW + 1;
  localparam int DEPTH  = MAX_SIZE * MAX_SIZE;
  localparam int AW     = $clog2(DEPTH);
  localparam int LW     = WEIGHT_BITS + IDXW + 2;
  localparam int SIZE_RST = (MAX_SIZE < 16) ? MAX_SIZE : 16;

  mwa_state_e state_q, state_d;

  logic [CW-1:0]          rr_q, rr_d, cc_q, cc_d;
  logic [CW-1:0]          root_q, root_d, depth_q, depth_d, k_q, k_d;
  logic [CW-1:0]          size_q, size_d;
  logic [WEIGHT_BITS-1:0] m_q, m_d;
  logic                   pop_q, pop_d;

  logic signed [LW-1:0]   rl_q [MAX_SIZE];
  logic signed [LW-1:0]   rl_d [MAX_SIZE];
  logic signed [LW-1:0]   cl_q [MAX_SIZE];
  logic signed [LW-1:0]   cl_d [MAX_SIZE];
  logic [IDXW:0]          owner_q [MAX_SIZE];
  logic [IDXW:0]          owner_d [MAX_SIZE];
  logic [IDXW-1:0]        srow_q [MAX_SIZE];
  logic [IDXW-1:0]        srow_d [MAX_SIZE];
  logic [IDXW-1:0]        scol_q [MAX_SIZE];
  logic [IDXW-1:0]        scol_d [MAX_SIZE];
  logic [MAX_SIZE-1:0]    rvis_q, rvis_d, cvis_q, cvis_d;

  logic                   ovalid_q, ovalid_d, olast_q, olast_d;
  logic [OUT_COL_W-1:0]   ocol_q, ocol_d;
  logic [OUT_ROW_W-1:0]   orow_q, orow_d;
  logic [PAIR_W-1:0]      opair_q, opair_d;
  logic [TOTAL_W-1:0]     total_q, total_d;

  logic [CW-1:0]          nm1, top;
  logic [IDXW-1:0]        ri, ci, sidx, arow, own_row;
  logic [IDXW-1:0]        sr, sc;
  logic                   own_unm;
  logic [AW-1:0]          addr;
  logic                   ram_we;
  logic [WEIGHT_BITS-1:0] rdata, mx;
  logic                   in_xfer, cfg_wr;
  logic [CFG_SIZE_W-1:0]  cfg_v;
  logic                   sl_clear, sl_take;
  slack_flags_t           sl_flags;
  logic signed [LW-1:0]   sl_min;
  logic [WEIGHT_BITS+PAIR_W-1:0] wext;
  logic [IDXW+OUT_COL_W-1:0]     cext;
  logic [IDXW+OUT_ROW_W-1:0]     rext;

  assign nm1     = size_q - CW'(1);
  assign top     = depth_q - CW'(1);
  assign ri      = rr_q[IDXW-1:0];
  assign ci      = cc_q[IDXW-1:0];
  assign sidx    = (state_q == ST_AUG) ? k_q[IDXW-1:0] : top[IDXW-1:0];
  assign sr      = srow_q[sidx];
  assign sc      = scol_q[sidx];
  assign own_unm = owner_q[ci][IDXW];
  assign own_row = owner_q[ci][IDXW-1:0];
  assign arow    = (state_q == ST_OUT_A) ? (own_unm ? '0 : own_row) : ri;
  assign addr    = AW'(arow) * AW'(MAX_SIZE) + AW'(ci);
  assign mx      = (rdata > m_q) ? rdata : m_q;

  assign in_xfer = wt_chan_i.valid && wt_chan_i.ready;
  assign ram_we  = in_xfer;
  assign cfg_wr  = psel && penable && pwrite && (paddr[2] == REG_SIZE_IN_USE);
  assign cfg_v   = pwdata[CFG_SIZE_W-1:0];

  assign wt_chan_i.ready = (state_q == ST_LOAD);
  assign pready          = 1'b1;
  assign prdata          = (paddr[2] == REG_SIZE_IN_USE) ? APB_DATA_W'(size_q) : '0;

  assign res_chan_o.valid         = ovalid_q;
  assign res_chan_o.column        = ocol_q;
  assign res_chan_o.assigned_row  = orow_q;
  assign res_chan_o.pair_weight   = opair_q;
  assign res_chan_o.running_total = total_q;
  assign res_chan_o.last          = olast_q;

  mwa_ram #(
    .WIDTH (WEIGHT_BITS),
    .DEPTH (DEPTH)
  ) u_wram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr),
    .wdata_i (wt_chan_i.weight),
    .raddr_i (addr),
    .rdata_o (rdata)
  );

  mwa_slack #(
    .WEIGHT_BITS (WEIGHT_BITS),
    .LW          (LW)
  ) u_slack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .row_label_i (rl_q[ri]),
    .col_label_i (cl_q[ci]),
    .weight_i    (rdata),
    .clear_i     (sl_clear),
    .take_i      (sl_take),
    .flags_o     (sl_flags),
    .min_o       (sl_min)
  );

  always_comb begin
    state_d  = state_q;
    rr_d     = rr_q;
    cc_d     = cc_q;
    root_d   = root_q;
    depth_d  = depth_q;
    k_d      = k_q;
    size_d   = size_q;
    m_d      = m_q;
    pop_d    = pop_q;
    rl_d     = rl_q;
    cl_d     = cl_q;
    owner_d  = owner_q;
    srow_d   = srow_q;
    scol_d   = scol_q;
    rvis_d   = rvis_q;
    cvis_d   = cvis_q;
    ovalid_d = ovalid_q;
    olast_d  = olast_q;
    ocol_d   = ocol_q;
    orow_d   = orow_q;
    opair_d  = opair_q;
    total_d  = total_q;
    sl_clear = 1'b0;
    sl_take  = 1'b0;
    wext     = '0;
    cext     = '0;
    rext     = '0;

    case (state_q)
      ST_LOAD: begin
        if (in_xfer) begin
          if (cc_q == nm1) begin
            cc_d = '0;
            if (rr_q == nm1) begin
              rr_d    = '0;
              m_d     = '0;
              state_d = ST_MAX_A;
            end else begin
              rr_d = rr_q + CW'(1);
            end
          end else begin
            cc_d = cc_q + CW'(1);
          end
        end
      end
      ST_MAX_A: begin
        state_d = ST_MAX_B;
      end
      ST_MAX_B: begin
        if (cc_q == nm1) begin
          rl_d[ri]    = $signed({{(LW - WEIGHT_BITS){1'b0}}, mx});
          cl_d[ri]    = '0;
          owner_d[ri] = {1'b1, {IDXW{1'b0}}};
          m_d         = '0;
          cc_d        = '0;
          if (rr_q == nm1) begin
            root_d  = '0;
            state_d = ST_ROOT;
          end else begin
            rr_d    = rr_q + CW'(1);
            state_d = ST_MAX_A;
          end
        end else begin
          m_d     = mx;
          cc_d    = cc_q + CW'(1);
          state_d = ST_MAX_A;
        end
      end
      ST_ROOT: begin
        rvis_d    = '0;
        rvis_d[root_q[IDXW-1:0]] = 1'b1;
        cvis_d    = '0;
        srow_d[0] = root_q[IDXW-1:0];
        scol_d[0] = '0;
        depth_d   = CW'(1);
        pop_d     = 1'b0;
        state_d   = ST_TOP;
      end
      ST_TOP: begin
        rr_d    = CW'(sr);
        cc_d    = CW'(sc) + CW'(pop_q);
        pop_d   = 1'b0;
        state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (cc_q >= size_q) begin
          depth_d = depth_q - CW'(1);
          if (depth_q == CW'(1)) begin
            // search failed: sweep all visited-row, free-column pairs
            sl_clear = 1'b1;
            rr_d     = '0;
            cc_d     = '0;
            state_d  = ST_REL_A;
          end else begin
            pop_d   = 1'b1;
            state_d = ST_TOP;
          end
        end else if (cvis_q[ci]) begin
          cc_d = cc_q + CW'(1);
        end else begin
          state_d = ST_TEST;
        end
      end
      ST_TEST: begin
        if (!sl_flags.tight) begin
          cc_d    = cc_q + CW'(1);
          state_d = ST_SCAN;
        end else begin
          scol_d[top[IDXW-1:0]] = ci;
          cvis_d[ci] = 1'b1;
          if (own_unm) begin
            k_d     = '0;
            state_d = ST_AUG;
          end else if (depth_q >= CW'(MAX_SIZE)) begin
            cc_d    = cc_q + CW'(1);
            state_d = ST_SCAN;
          end else begin
            srow_d[depth_q[IDXW-1:0]] = own_row;
            scol_d[depth_q[IDXW-1:0]] = '0;
            rvis_d[own_row] = 1'b1;
            depth_d = depth_q + CW'(1);
            rr_d    = CW'(own_row);
            cc_d    = '0;
            state_d = ST_SCAN;
          end
        end
      end
      ST_AUG: begin
        owner_d[sc] = {1'b0, sr};
        k_d = k_q + CW'(1);
        if (k_q == top) begin
          if (root_q == nm1) begin
            cc_d    = '0;
            total_d = '0;
            state_d = ST_OUT_A;
          end else begin
            root_d  = root_q + CW'(1);
            state_d = ST_ROOT;
          end
        end
      end
      ST_REL_A, ST_REL_B: begin
        if (state_q == ST_REL_A && rvis_q[ri] && !cvis_q[ci]) begin
          state_d = ST_REL_B;
        end else begin
          sl_take = (state_q == ST_REL_B);
          state_d = ST_REL_A;
          if (cc_q == nm1) begin
            cc_d = '0;
            if (rr_q == nm1) begin
              state_d = ST_REL_APPLY;
            end else begin
              rr_d = rr_q + CW'(1);
            end
          end else begin
            cc_d = cc_q + CW'(1);
          end
        end
      end
      ST_REL_APPLY: begin
        if (sl_flags.positive) begin
          for (int i = 0; i < MAX_SIZE; i++) begin
            if (rvis_q[i]) begin
              rl_d[i] = rl_q[i] - sl_min;
            end
            if (cvis_q[i]) begin
              cl_d[i] = cl_q[i] + sl_min;
            end
          end
          state_d = ST_ROOT;
        end else if (root_q == nm1) begin
          cc_d    = '0;
          total_d = '0;
          state_d = ST_OUT_A;
        end else begin
          root_d  = root_q + CW'(1);
          state_d = ST_ROOT;
        end
      end
      ST_OUT_A: begin
        state_d = ST_OUT_B;
      end
      ST_OUT_B: begin
        wext     = own_unm ? '0 : {{PAIR_W{1'b0}}, rdata};
        cext     = {{OUT_COL_W{1'b0}}, ci};
        rext     = {{OUT_ROW_W{1'b0}}, (own_unm ? {IDXW{1'b0}} : own_row)};
        ocol_d   = cext[OUT_COL_W-1:0];
        orow_d   = rext[OUT_ROW_W-1:0];
        opair_d  = wext[PAIR_W-1:0];
        total_d  = total_q + TOTAL_W'(wext[PAIR_W-1:0]);
        olast_d  = (cc_q == nm1);
        ovalid_d = 1'b1;
        state_d  = ST_OUT_C;
      end
      ST_OUT_C: begin
        if (res_chan_o.ready) begin
          ovalid_d = 1'b0;
          if (olast_q) begin
            rr_d    = '0;
            cc_d    = '0;
            state_d = ST_LOAD;
          end else begin
            cc_d    = cc_q + CW'(1);
            state_d = ST_OUT_A;
          end
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase

    // size write clears the row and column counters (restarts loading in ST_LOAD)
    if (cfg_wr) begin
      if (cfg_v == '0) begin
        size_d = CW'(1);
      end else if (int'(cfg_v) > MAX_SIZE) begin
        size_d = CW'(MAX_SIZE);
      end else begin
        size_d = CW'(cfg_v);
      end
      rr_d = '0;
      cc_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      rr_q     <= '0;
      cc_q     <= '0;
      root_q   <= '0;
      depth_q  <= '0;
      k_q      <= '0;
      size_q   <= CW'(SIZE_RST);
      pop_q    <= 1'b0;
      rvis_q   <= '0;
      cvis_q   <= '0;
      ovalid_q <= 1'b0;
      for (int i = 0; i < MAX_SIZE; i++) begin
        owner_q[i] <= {1'b1, {IDXW{1'b0}}};
        rl_q[i]    <= '0;
        cl_q[i]    <= '0;
      end
    end else begin
      state_q  <= state_d;
      rr_q     <= rr_d;
      cc_q     <= cc_d;
      root_q   <= root_d;
      depth_q  <= depth_d;
      k_q      <= k_d;
      size_q   <= size_d;
      pop_q    <= pop_d;
      rvis_q   <= rvis_d;
      cvis_q   <= cvis_d;
      ovalid_q <= ovalid_d;
      owner_q  <= owner_d;
      rl_q     <= rl_d;
      cl_q     <= cl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q     <= m_d;
    srow_q  <= srow_d;
    scol_q  <= scol_d;
    olast_q <= olast_d;
    ocol_q  <= ocol_d;
    orow_q  <= orow_d;
    opair_q <= opair_d;
    total_q <= total_d;
  end

  // search stack never grows past the matrix bound
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= CW'(MAX_SIZE))
    else $error("search stack overflow");

  // results only leave while no weight can be taken
  a_out_not_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_chan_o.valid |-> !wt_chan_i.ready)
    else $error("result pending during load");

  // augmentation walks only live stack entries
  a_aug_in_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_AUG) |-> (k_q < depth_q))
    else $error("augment index beyond stack");

  // a finished column is followed by the next column or by loading
  a_out_next: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_chan_o.valid && res_chan_o.ready) |=>
      ((state_q == ST_OUT_A) || (state_q == ST_LOAD)))
    else $error("bad state after result transaction");

endmodule

@@ tb/mwa_checker.sv @@
// ----------------------------------------------------------------------------
// mwa_checker
// Scoreboard for the assignment solver. It follows the configuration port and
// the weight channel, solves each completed matrix with its own Kuhn-Munkres
// model and checks every assignment pair that the block hands out.
// ----------------------------------------------------------------------------
module mwa_checker import mwa_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  mwa_in_if                     wt_chan,
  mwa_out_if                    res_chan,
  input  logic                  psel_i,
  input  logic                  penable_i,
  input  logic                  pwrite_i,
  input  logic                  pready_i,
  input  logic [APB_ADDR_W-1:0] paddr_i,
  input  logic [APB_DATA_W-1:0] pwdata_i,
  output int                    fail_count_o,
  output int                    pending_o,
  output int                    solved_o,
  output int                    checked_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DIM_MAX = 16;
  localparam longint NO_SLACK = 64'h3f3f3f3f;

  typedef struct packed {
    logic [OUT_COL_W-1:0] column;
    logic [OUT_ROW_W-1:0] assigned_row;
    logic [PAIR_W-1:0]    pair_weight;
    logic [TOTAL_W-1:0]   running_total;
    logic                 last;
  } pair_t;

  pair_t       expected_pairs[$];
  int unsigned dim;
  int unsigned fill;
  logic [15:0] wmat[DIM_MAX][DIM_MAX];
  longint      row_lab[DIM_MAX];
  longint      col_lab[DIM_MAX];
  int          owner[DIM_MAX];
  bit          row_seen[DIM_MAX];
  bit          col_seen[DIM_MAX];
  int          path_row[DIM_MAX];
  int          path_col[DIM_MAX];

  // depth-first search for an augmenting path from one root row
  function automatic bit augment(int root);
    int depth;
    int top;
    int r;
    int c;
    depth = 1;
    path_row[0] = root;
    path_col[0] = 0;
    row_seen[root] = 1'b1;
    while (depth > 0) begin
      top = depth - 1;
      r = path_row[top];
      c = path_col[top];
      while (c < int'(dim) && (col_seen[c] ||
             row_lab[r] + col_lab[c] != longint'(wmat[r][c])))
        c++;
      if (c >= int'(dim)) begin
        depth--;
        if (depth > 0) path_col[depth-1]++;
        continue;
      end
      path_col[top] = c;
      col_seen[c] = 1'b1;
      if (owner[c] < 0) begin
        for (int k = 0; k < depth; k++) owner[path_col[k]] = path_row[k];
        return 1'b1;
      end
      if (depth >= DIM_MAX) begin
        path_col[top]++;
        continue;
      end
      path_row[depth] = owner[c];
      path_col[depth] = 0;
      row_seen[owner[c]] = 1'b1;
      depth++;
    end
    return 1'b0;
  endfunction

  function automatic bit shift_labels();
    longint slack;
    longint s;
    slack = NO_SLACK;
    for (int r = 0; r < int'(dim); r++) begin
      if (!row_seen[r]) continue;
      for (int c = 0; c < int'(dim); c++) begin
        if (!col_seen[c]) begin
          s = row_lab[r] + col_lab[c] - longint'(wmat[r][c]);
          if (s < slack) slack = s;
        end
      end
    end
    if (slack == NO_SLACK || slack <= 0) return 1'b0;
    for (int r = 0; r < int'(dim); r++) begin
      if (row_seen[r]) row_lab[r] -= slack;
      if (col_seen[r]) col_lab[r] += slack;
    end
    return 1'b1;
  endfunction

  function automatic void solve_matrix();
    longint m;
    longint total;
    pair_t  p;
    for (int r = 0; r < int'(dim); r++) begin
      m = 0;
      owner[r] = -1;
      col_lab[r] = 0;
      for (int c = 0; c < int'(dim); c++)
        if (longint'(wmat[r][c]) > m) m = longint'(wmat[r][c]);
      row_lab[r] = m;
    end
    for (int r = 0; r < int'(dim); r++) begin
      forever begin
        row_seen = '{default: 1'b0};
        col_seen = '{default: 1'b0};
        if (augment(r)) break;
        if (!shift_labels()) break;
      end
    end
    total = 0;
    for (int c = 0; c < int'(dim); c++) begin
      p.column = c[OUT_COL_W-1:0];
      if (owner[c] < 0) begin
        p.assigned_row = '0;
        p.pair_weight  = '0;
      end else begin
        p.assigned_row = owner[c][OUT_ROW_W-1:0];
        p.pair_weight  = wmat[owner[c]][c];
      end
      total += longint'(p.pair_weight);
      p.running_total = total[TOTAL_W-1:0];
      p.last = (c == int'(dim) - 1);
      expected_pairs.insert(expected_pairs.size(), p);
    end
  endfunction

  function automatic void check_pair(pair_t got);
    pair_t exp_p;
    if (expected_pairs.size() == 0) begin
      $error("unexpected result transaction: column %0d", got.column);
      fail_count_o++;
      return;
    end
    exp_p = expected_pairs.pop_front();
    checked_o++;
    if (got.column !== exp_p.column) begin
      $error("column: expected %0d, actual %0d", exp_p.column, got.column);
      fail_count_o++;
    end
    if (got.assigned_row !== exp_p.assigned_row) begin
      $error("assigned_row: expected %0d, actual %0d", exp_p.assigned_row, got.assigned_row);
      fail_count_o++;
    end
    if (got.pair_weight !== exp_p.pair_weight) begin
      $error("pair_weight: expected %0d, actual %0d", exp_p.pair_weight, got.pair_weight);
      fail_count_o++;
    end
    if (got.running_total !== exp_p.running_total) begin
      $error("running_total: expected %0d, actual %0d",
             exp_p.running_total, got.running_total);
      fail_count_o++;
    end
    if (got.last !== exp_p.last) begin
      $error("last: expected %0d, actual %0d", exp_p.last, got.last);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dim          <= DIM_MAX;
      fill         <= 0;
      fail_count_o <= 0;
      pending_o    <= 0;
      solved_o     <= 0;
      checked_o    <= 0;
      expected_pairs.delete();
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i &&
          paddr_i[APB_ADDR_W-1:2] == REG_SIZE_IN_USE) begin
        // zero reads as one, anything above the array size saturates
        if (pwdata_i[CFG_SIZE_W-1:0] == 0) dim = 1;
        else if (pwdata_i[CFG_SIZE_W-1:0] > DIM_MAX) dim = DIM_MAX;
        else dim = pwdata_i[CFG_SIZE_W-1:0];
        fill = 0;
      end
      if (wt_chan.valid && wt_chan.ready) begin
        wmat[fill / dim][fill % dim] = wt_chan.weight;
        fill++;
        if (fill == dim * dim) begin
          fill = 0;
          solve_matrix();
          solved_o++;
        end
      end
      if (res_chan.valid && res_chan.ready)
        check_pair({res_chan.column, res_chan.assigned_row, res_chan.pair_weight,
                    res_chan.running_total, res_chan.last});
      pending_o <= expected_pairs.size();
    end
  end

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the assignment solver: size settings over the register port,
// directed matrices for the corner cases, then random matrices with bursty
// weight traffic and a stalling result sink. The checker gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import mwa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [APB_ADDR_W-1:0] SIZE_ADDR     = {REG_SIZE_IN_USE, 2'b00};
  localparam logic [APB_ADDR_W-1:0] UNMAPPED_ADDR = 3'd4;
  localparam int                    CYCLE_LIMIT   = 1500000;
  localparam int                    SETTLE_CYCLES = 40;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;
  int                    fail_count;
  int                    pending;
  int                    solved;
  int                    checked;
  int                    cycles;
  int                    burst_left;
  int                    stall_mode;
  int                    items;

  mwa_in_if #(.WEIGHT_BITS(16)) wt_chan ();
  mwa_out_if res_chan ();

  max_weight_assignment_solver_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wt_chan_i  (wt_chan),
    .res_chan_o (res_chan),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  mwa_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .wt_chan      (wt_chan),
    .res_chan     (res_chan),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .pready_i     (pready),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .solved_o     (solved),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // result sink: switches between always ready, random and long stalls
  always @(posedge clk_i) begin
    if (cycles % 48 == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0: res_chan.ready <= 1'b1;
      1: res_chan.ready <= 1'($urandom_range(0, 1));
      default: res_chan.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  task automatic send_weight(logic [15:0] w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        wt_chan.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    wt_chan.valid  <= 1'b1;
    wt_chan.weight <= w;
    do @(posedge clk_i); while (!wt_chan.ready);
    burst_left--;
    items++;
  endtask

  // the block is idle only once every pair is out and the solver has settled
  task automatic wait_drained();
    wt_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [APB_ADDR_W-1:0] addr, logic [APB_DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // 0 wide random, 1 narrow values full of ties, 2 only the extremes
  task automatic send_matrix(int n, int flavor);
    for (int k = 0; k < n * n; k++) begin
      case (flavor)
        0: send_weight(16'($urandom_range(0, 65535)));
        1: send_weight(16'($urandom_range(0, 3)));
        default: send_weight($urandom_range(0, 1) ? 16'hffff : 16'h0000);
      endcase
    end
  endtask

  initial begin
    int n;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    wt_chan.valid  = 1'b0;
    wt_chan.weight = '0;
    res_chan.ready = 1'b1;
    cycles         = 0;
    stall_mode     = 0;
    burst_left     = 0;
    items          = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // size zero is taken as one
    reg_write(SIZE_ADDR, 32'd0);
    send_weight(16'h0000);
    send_weight(16'hffff);
    wait_drained();
    // unmapped register must leave the size alone
    reg_write(UNMAPPED_ADDR, 32'd5);
    send_weight(16'h1234);
    wait_drained();
    reg_write(SIZE_ADDR, 32'hffff_ffe2);
    send_weight(16'hffff); send_weight(16'h0000);
    send_weight(16'h0000); send_weight(16'hffff);
    repeat (4) send_weight(16'd7);
    wait_drained();
    // rewrite of the size in the middle of a matrix restarts loading
    reg_write(SIZE_ADDR, 32'd3);
    repeat (4) send_weight(16'($urandom_range(0, 65535)));
    wait_drained();
    reg_write(SIZE_ADDR, 32'd3);
    send_matrix(3, 1);
    wait_drained();
    // oversized value saturates to the largest matrix, left partly loaded
    reg_write(SIZE_ADDR, 32'd31);
    repeat (6) send_weight(16'($urandom_range(0, 65535)));
    wait_drained();

    while (items < 120) begin
      n = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 5);
      reg_write(SIZE_ADDR, n);
      repeat ($urandom_range(1, 2)) send_matrix(n, $urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
        // abandoned partial matrix
        repeat ($urandom_range(1, n * n)) send_weight(16'($urandom_range(0, 65535)));
      end
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("tb: solved %0d matrices and checked %0d assignment pairs", solved, checked);
    $display("tb: sizes 1 to 5, zero, oversized and unmapped writes, restarts, ties");
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/mwa_pkg.sv
rtl/core/mwa_if.sv
rtl/core/mwa_ram.sv
rtl/core/mwa_slack.sv
rtl/core/max_weight_assignment_solver_top.sv
tb/mwa_checker.sv
tb/tb_top.sv
